>>> sv/rqt_pkg.sv
// ----------------------------------------------------------------------------
// rqt_pkg: shared types and constants of the resource quota table
// Codes, widths and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package rqt_pkg;

    localparam int TableDepth = 64;
    localparam int KeyW   = 16;
    localparam int ValW   = 64;
    localparam int ActW   = 3;
    localparam int StatW  = 2;
    localparam int PctW   = 16;

    localparam logic [ActW-1:0] ACT_SET     = 3'd0;
    localparam logic [ActW-1:0] ACT_READ    = 3'd1;
    localparam logic [ActW-1:0] ACT_ADD     = 3'd2;
    localparam logic [ActW-1:0] ACT_CHECK   = 3'd3;
    localparam logic [ActW-1:0] ACT_PERCENT = 3'd4;
    localparam logic [ActW-1:0] ACT_RESET   = 3'd5;

    localparam logic [StatW-1:0] ST_OK        = 2'd0;
    localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [StatW-1:0] ST_FULL      = 2'd2;
    localparam logic [StatW-1:0] ST_CLAMPED   = 2'd3;

    localparam logic [PctW-1:0] PercentMax = 16'hFFFF;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, start search
        logic scan;      // compare key read at current index
        logic fetch;     // capture limit/usage of hit entry
        logic exec;      // evaluate action
        logic div_start;
        logic write;     // write back entry
        logic append;    // write new entry
        logic finish;    // build result
    } rqt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic scan_done;
        logic full;
        logic div_busy;
        logic is_pct;
        logic bad_act;
        logic is_set;
    } rqt_sts_t;

endpackage

>>> sv/rqt_ram.sv
// ----------------------------------------------------------------------------
// rqt_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rqt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/rqt_div.sv
// ----------------------------------------------------------------------------
// rqt_div: serial percent unit
// Restoring division of usage*100 by limit, one quotient bit per cycle,
// saturating at 65535.
// ----------------------------------------------------------------------------
module rqt_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [rqt_pkg::ValW-1:0] num,
    input  logic [rqt_pkg::ValW-1:0] den,
    output logic                    busy,
    output logic [rqt_pkg::PctW-1:0] pct
);

    localparam int NumW = rqt_pkg::ValW + 7;
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0]            num_reg, num_next;
    logic [rqt_pkg::ValW:0]     rem_reg, rem_next;
    logic [rqt_pkg::ValW-1:0]   den_reg, den_next;
    logic [NumW-1:0]            quo_reg, quo_next;
    logic [CntW-1:0]            cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [rqt_pkg::ValW+1:0]   trial;
    logic [rqt_pkg::ValW:0]     shifted;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[rqt_pkg::ValW-1:0], num_reg[NumW-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (start)
        begin
            // usage*100 = usage*64 + usage*32 + usage*4
            num_next  = ({7'd0, num} << 6) + ({7'd0, num} << 5) + ({7'd0, num} << 2);
            rem_next  = '0;
            den_next  = den;
            quo_next  = '0;
            cnt_next  = CntW'(NumW);
            busy_next = (den != '0);
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NumW-2:0], 1'b0};
            if (!trial[rqt_pkg::ValW+1])
            begin
                rem_next = trial[rqt_pkg::ValW:0];
                quo_next = {quo_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign pct  = (den_reg == '0) ? '0 :
                  (quo_reg[NumW-1:rqt_pkg::PctW] != '0) ? rqt_pkg::PercentMax :
                  quo_reg[rqt_pkg::PctW-1:0];

endmodule

>>> sv/rqt_datapath.sv
// ----------------------------------------------------------------------------
// rqt_datapath: entry storage, key search and action arithmetic
// Holds the request, scans keys, updates limit and usage, forms the result.
// ----------------------------------------------------------------------------
module rqt_datapath #(
    parameter int TABLE_DEPTH = rqt_pkg::TableDepth
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rqt_pkg::rqt_cmd_t         cmd,
    output rqt_pkg::rqt_sts_t         sts,
    input  logic [rqt_pkg::ActW-1:0]  in_action,
    input  logic [rqt_pkg::KeyW-1:0]  in_key,
    input  logic [rqt_pkg::ValW-1:0]  in_value,
    output logic [rqt_pkg::StatW-1:0] status,
    output logic                      fits,
    output logic [rqt_pkg::PctW-1:0]  percent_used,
    output logic [rqt_pkg::ValW-1:0]  limit_out,
    output logic [rqt_pkg::ValW-1:0]  usage_out
);

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    logic [rqt_pkg::ActW-1:0]  act_reg;
    logic [rqt_pkg::KeyW-1:0]  key_reg;
    logic [rqt_pkg::ValW-1:0]  val_reg;
    logic [CntW-1:0]           count_reg;
    logic [CntW-1:0]           idx_reg;
    logic                      hit_reg;
    logic                      app_reg;
    logic [rqt_pkg::ValW-1:0]  lim_reg, use_reg;
    logic                      fits_reg;
    logic [rqt_pkg::StatW-1:0] st_reg;
    logic                      scan_cmp;

    logic [rqt_pkg::StatW-1:0] status_reg;
    logic                      fits_out_reg;
    logic [rqt_pkg::PctW-1:0]  pct_out_reg;
    logic [rqt_pkg::ValW-1:0]  lim_out_reg, use_out_reg;

    logic [rqt_pkg::StatW-1:0] res_status;
    logic                      res_fits;
    logic [rqt_pkg::PctW-1:0]  res_pct;
    logic [rqt_pkg::ValW-1:0]  res_lim, res_use;

    logic [IdxW-1:0]           addr;
    logic                      we;
    logic [rqt_pkg::KeyW-1:0]  key_rd;
    logic [rqt_pkg::ValW-1:0]  lim_rd, use_rd, lim_wr, use_wr;
    logic [rqt_pkg::ValW:0]    sum;
    logic [rqt_pkg::PctW-1:0]  pct;
    logic                      div_busy;

    assign addr   = idx_reg[IdxW-1:0];
    assign we     = cmd.write || cmd.append;
    assign lim_wr = cmd.append ? val_reg : lim_reg;
    assign use_wr = cmd.append ? '0 : use_reg;
    assign sum    = {1'b0, use_reg} + {1'b0, val_reg};

    rqt_ram #(.WIDTH(rqt_pkg::KeyW), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk(clk), .we(cmd.append), .addr(addr), .wdata(key_reg), .rdata(key_rd)
    );
    rqt_ram #(.WIDTH(rqt_pkg::ValW), .DEPTH(TABLE_DEPTH)) u_lims (
        .clk(clk), .we(we), .addr(addr), .wdata(lim_wr), .rdata(lim_rd)
    );
    rqt_ram #(.WIDTH(rqt_pkg::ValW), .DEPTH(TABLE_DEPTH)) u_uses (
        .clk(clk), .we(we), .addr(addr), .wdata(use_wr), .rdata(use_rd)
    );

    rqt_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .num(use_reg), .den(lim_reg), .busy(div_busy), .pct(pct)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            scan_cmp  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                scan_cmp <= 1'b0;
            end
            else if (cmd.scan)
            begin
                // RAM output belongs to idx_reg once scan_cmp is set
                if (scan_cmp && idx_reg < count_reg && key_rd == key_reg)
                begin
                    hit_reg <= 1'b1;
                end
                else if (scan_cmp)
                begin
                    idx_reg  <= idx_reg + 1'b1;
                    scan_cmp <= 1'b0;
                end
                else
                begin
                    scan_cmp <= 1'b1;
                end
            end
            if (cmd.append)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        res_status = rqt_pkg::ST_OK;
        res_fits   = 1'b0;
        res_pct    = '0;
        res_lim    = '0;
        res_use    = '0;
        if (act_reg > rqt_pkg::ACT_RESET)
        begin
        end
        else if (hit_reg)
        begin
            res_status = st_reg;
            res_fits   = fits_reg;
            res_pct    = (act_reg == rqt_pkg::ACT_PERCENT) ? pct : '0;
            res_lim    = lim_reg;
            res_use    = use_reg;
        end
        else if (act_reg == rqt_pkg::ACT_SET)
        begin
            if (app_reg)
            begin
                res_lim = val_reg;
            end
            else
            begin
                res_status = rqt_pkg::ST_FULL;
            end
        end
        else
        begin
            res_status = rqt_pkg::ST_NOT_FOUND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= in_action;
            key_reg  <= in_key;
            val_reg  <= in_value;
            fits_reg <= 1'b0;
            st_reg   <= rqt_pkg::ST_OK;
            app_reg  <= 1'b0;
        end
        if (cmd.append)
        begin
            app_reg <= 1'b1;
        end
        if (cmd.fetch)
        begin
            lim_reg <= lim_rd;
            use_reg <= use_rd;
        end
        if (cmd.exec)
        begin
            case (act_reg)
                rqt_pkg::ACT_SET:
                begin
                    lim_reg <= val_reg;
                end
                rqt_pkg::ACT_ADD:
                begin
                    if (sum[rqt_pkg::ValW] || sum[rqt_pkg::ValW-1:0] > lim_reg)
                    begin
                        use_reg <= lim_reg;
                        st_reg  <= rqt_pkg::ST_CLAMPED;
                    end
                    else
                    begin
                        use_reg <= sum[rqt_pkg::ValW-1:0];
                    end
                end
                rqt_pkg::ACT_CHECK:
                begin
                    fits_reg <= !sum[rqt_pkg::ValW] && sum[rqt_pkg::ValW-1:0] <= lim_reg;
                end
                rqt_pkg::ACT_RESET:
                begin
                    use_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.finish)
        begin
            status_reg   <= res_status;
            fits_out_reg <= res_fits;
            pct_out_reg  <= res_pct;
            lim_out_reg  <= res_lim;
            use_out_reg  <= res_use;
        end
    end

    assign status       = status_reg;
    assign fits         = fits_out_reg;
    assign percent_used = pct_out_reg;
    assign limit_out    = lim_out_reg;
    assign usage_out    = use_out_reg;

    assign sts.hit       = hit_reg;
    assign sts.scan_done = hit_reg || (idx_reg >= count_reg);
    assign sts.full      = (count_reg >= CntW'(TABLE_DEPTH));
    assign sts.div_busy  = div_busy;
    assign sts.is_pct    = (act_reg == rqt_pkg::ACT_PERCENT);
    assign sts.bad_act   = (act_reg > rqt_pkg::ACT_RESET);
    assign sts.is_set    = (act_reg == rqt_pkg::ACT_SET);

endmodule

>>> sv/rqt_ctrl.sv
// ----------------------------------------------------------------------------
// rqt_ctrl: request sequencer
// Search; on a hit fetch, action, percent divide, write-back; then output.
// ----------------------------------------------------------------------------
module rqt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  rqt_pkg::rqt_sts_t sts,
    output rqt_pkg::rqt_cmd_t cmd,
    output logic              in_ready,
    output logic              out_valid
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_FETCH  = 4'd2;
    localparam logic [3:0] S_FETCH2 = 4'd3;
    localparam logic [3:0] S_EXEC   = 4'd4;
    localparam logic [3:0] S_DIVST  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_WRITE  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.bad_act)
                begin
                    state_next = S_FIN;
                end
                else if (sts.hit)
                begin
                    state_next = S_FETCH;
                end
                else if (sts.scan_done)
                begin
                    if (sts.is_set && !sts.full)
                    begin
                        cmd.append = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_FETCH:
            begin
                state_next = S_FETCH2;
            end
            S_FETCH2:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.is_pct ? S_DIVST : S_WRITE;
            end
            S_DIVST:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready and valid together");
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_SCAN)
        else $error("accept did not start search");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> in_ready)
        else $error("no return to idle");
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented");
`endif

endmodule

>>> sv/resource_quota_table_core.sv
// ----------------------------------------------------------------------------
// resource_quota_table_core: quota table of keyed limit and usage entries
// Requests set, read, add, check, percent or reset usage of one entry.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = action, tdata = {value, key}.
//   m_axis returns one result per request: tuser = status,
//   tdata = {usage_out, limit_out, percent_used, fits}.
//   One request at a time. The key search reads the stored entries in turn
//   through the entry RAMs and compares each key once its registered read
//   data is back; a hit then fetches, acts and writes back, a miss ends the
//   search at the entry count. Percent adds the serial divider run (one
//   quotient bit a cycle over 71 bits, plus start and hand-over).
//   s_axis_tready is high only while idle; the result holds on m_axis until
//   m_axis_tready takes it, and the next request is taken from the cycle after.
//   Reset empties the table (entry count zero); RAM contents are not cleared.
// ----------------------------------------------------------------------------
module resource_quota_table_core #(
    parameter int TABLE_DEPTH = rqt_pkg::TableDepth
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // key[15:0], value[79:16]
    input  logic [2:0]   s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // fits[0], percent_used[16:1], limit_out[80:17],
                                         // usage_out[144:81], zero[151:145]
    output logic [1:0]   m_axis_tuser    // status
);

    rqt_pkg::rqt_cmd_t cmd;
    rqt_pkg::rqt_sts_t sts;
    logic              fits;
    logic [15:0]       pct;
    logic [63:0]       lim_o, use_o;

    rqt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .sts(sts), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    rqt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_action(s_axis_tuser), .in_key(s_axis_tdata[15:0]),
        .in_value(s_axis_tdata[79:16]),
        .status(m_axis_tuser), .fits(fits), .percent_used(pct),
        .limit_out(lim_o), .usage_out(use_o)
    );

    assign m_axis_tdata = {7'd0, use_o, lim_o, pct, fits};

endmodule
